/* rtl/ili_pkg.sv */
// Shared constants, codes and types for the indexed list block.
`default_nettype none
package ili_pkg;
  localparam int CAPACITY = 16;
  localparam int DATA_W = 32;
  localparam int POS_W = 5;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] STATUS_DONE = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic ins;
    logic del;
    logic [CMP_W-1:0] pos;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;
endpackage
`default_nettype wire

/* rtl/ili_cell.sv */
// One list slot: holds an entry, shifts from its neighbors and joins the read chain.
`default_nettype none
module ili_cell (
  input  wire logic                            clk_i,
  input  wire ili_pkg::cell_ctrl_t             ctrl_i,
  input  wire logic [ili_pkg::CMP_W-1:0]       idx_i,
  input  wire logic [ili_pkg::DATA_W-1:0]      prev_i,
  input  wire logic [ili_pkg::DATA_W-1:0]      next_i,
  input  wire logic [ili_pkg::DATA_W-1:0]      rd_i,
  output logic      [ili_pkg::DATA_W-1:0]      entry_o,
  output logic      [ili_pkg::DATA_W-1:0]      rd_o
);
  logic [ili_pkg::DATA_W-1:0] entry_q, entry_d;
  logic at_pos, past_pos, we;

  assign at_pos = (idx_i == ctrl_i.pos);
  assign past_pos = (idx_i >= ctrl_i.pos);
  assign we = (ctrl_i.ins || ctrl_i.del) && past_pos;

  always_comb begin
    if (ctrl_i.ins) begin
      entry_d = at_pos ? ctrl_i.value : prev_i;
    end else begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;
  assign rd_o = rd_i | (at_pos ? entry_q : '0);
endmodule
`default_nettype wire

/* rtl/indexed_list_insert_delete.sv */
// Top level of the indexed list: request decode, cell row and result register.
// Bounded ordered list of 16 signed 32-bit entries with insert, delete and
// read at a position. One request is taken per clock; its result appears in
// the output register on the next cycle, and a new request is taken while a
// result waits unless the output is stalled. Every insert or delete shifts
// all affected slots of the cell row in that single cycle, and a read walks
// the slot row's OR chain. Entries need no clearing after reset: only
// positions below the count are ever read.
`default_nettype none
module indexed_list_insert_delete (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  op_i,
  input  wire logic [ili_pkg::POS_W-1:0]   position_i,
  input  wire logic signed [31:0]          value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [1:0]                       status_o,
  output logic signed [31:0]               read_value_o,
  output logic [ili_pkg::POS_W-1:0]        entry_count_o
);
  logic accept;
  logic [ili_pkg::CNT_W-1:0] count_q, count_d;
  logic [ili_pkg::CMP_W-1:0] pos_ext, count_ext;
  logic in_range_ins, in_range_acc, full;
  logic [1:0] status_d;
  logic rd_sel;
  logic [ili_pkg::DATA_W-1:0] rd_d;
  ili_pkg::cell_ctrl_t ctrl;
  logic out_valid_q;
  logic [1:0] status_q;
  logic [ili_pkg::DATA_W-1:0] rd_q;
  logic [ili_pkg::CMP_W-1:0] cnt_out_q;

  logic [ili_pkg::DATA_W-1:0] ent [ili_pkg::CAPACITY];
  logic [ili_pkg::DATA_W-1:0] rd_chain [ili_pkg::CAPACITY+1];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept = in_valid_i && !in_stall_o;

  assign pos_ext = ili_pkg::CMP_W'(position_i);
  assign count_ext = ili_pkg::CMP_W'(count_q);
  assign in_range_ins = (pos_ext <= count_ext);
  assign in_range_acc = (pos_ext < count_ext);
  assign full = (count_ext >= ili_pkg::CMP_W'(ili_pkg::CAPACITY));

  always_comb begin
    ctrl.ins = 1'b0;
    ctrl.del = 1'b0;
    ctrl.pos = pos_ext;
    ctrl.value = value_i;
    status_d = ili_pkg::STATUS_DONE;
    rd_sel = 1'b0;
    count_d = count_q;
    case (op_i)
      ili_pkg::OP_INSERT: begin
        if (!in_range_ins) begin
          status_d = ili_pkg::STATUS_RANGE;
        end else if (full) begin
          status_d = ili_pkg::STATUS_FULL;
        end else begin
          ctrl.ins = accept;
          count_d = count_q + 1'b1;
        end
      end
      ili_pkg::OP_DELETE: begin
        if (!in_range_acc) begin
          status_d = ili_pkg::STATUS_RANGE;
        end else begin
          ctrl.del = accept;
          count_d = count_q - 1'b1;
        end
      end
      default: begin
        if (!in_range_acc) begin
          status_d = ili_pkg::STATUS_RANGE;
        end else begin
          rd_sel = 1'b1;
        end
      end
    endcase
  end

  assign rd_d = rd_sel ? rd_chain[ili_pkg::CAPACITY] : '0;

  assign rd_chain[0] = '0;

  for (genvar i = 0; i < ili_pkg::CAPACITY; i++) begin : g_cell
    logic [ili_pkg::DATA_W-1:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = value_i;
    end else begin : g_mid
      assign prev_w = ent[i-1];
    end
    if (i == ili_pkg::CAPACITY - 1) begin : g_last
      assign next_w = ent[i];
    end else begin : g_inner
      assign next_w = ent[i+1];
    end
    ili_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (ili_pkg::CMP_W'(i)),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .rd_i    (rd_chain[i]),
      .entry_o (ent[i]),
      .rd_o    (rd_chain[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rd_q <= rd_d;
      cnt_out_q <= ili_pkg::CMP_W'(count_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign read_value_o = rd_q;
  assign entry_count_o = cnt_out_q[ili_pkg::POS_W-1:0];
endmodule
`default_nettype wire

/* tb/indexed_list_insert_delete_tb.sv */
// Testbench for the indexed list: directed and random requests checked against a built-in list model.
`default_nettype none
module indexed_list_insert_delete_tb;
  import ili_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [31:0] VALUE_MAX = 32'h7fff_ffff;
  localparam logic [31:0] VALUE_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      read_value;
    logic [POS_W-1:0] entry_count;
  } list_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        op_i = OP_READ;
  logic [POS_W-1:0]  position_i = '0;
  logic signed [31:0] value_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        status_o;
  logic signed [31:0] read_value_o;
  logic [POS_W-1:0]  entry_count_o;

  logic [31:0]       entry_model [CAPACITY];
  int unsigned       held_count = 0;
  list_result_t      pending_results [$];
  list_result_t      due;
  int unsigned       fail_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       stall_left = 0;
  bit                idle_en = 1'b1;

  indexed_list_insert_delete u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .entry_count_o (entry_count_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic list_result_t apply_request(input logic [1:0] op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [31:0] val);
    list_result_t r;
    int unsigned  i;
    r = '0;
    r.status = STATUS_DONE;
    if (op == OP_INSERT) begin
      if (pos > held_count) begin
        r.status = STATUS_RANGE;
      end else if (held_count >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        for (i = held_count; i > pos; i--) entry_model[i] = entry_model[i-1];
        entry_model[pos] = val;
        held_count++;
      end
    end else if (op == OP_DELETE) begin
      if (pos >= held_count) begin
        r.status = STATUS_RANGE;
      end else begin
        for (i = pos; i + 1 < held_count; i++) entry_model[i] = entry_model[i+1];
        held_count--;
      end
    end else begin
      if (pos >= held_count) begin
        r.status = STATUS_RANGE;
      end else begin
        r.read_value = entry_model[pos];
      end
    end
    r.entry_count = held_count[POS_W-1:0];
    return r;
  endfunction

  function automatic logic [POS_W-1:0] pick_position(input logic [1:0] op);
    if ($urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 31));
    if (op == OP_INSERT) return POS_W'($urandom_range(0, held_count));
    if (held_count == 0) return POS_W'($urandom_range(0, 31));
    return POS_W'($urandom_range(0, held_count - 1));
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [POS_W-1:0] pos,
                              input logic [31:0] val);
    int unsigned gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    position_i <= pos;
    value_i <= val;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_results.push_back(apply_request(op, pos, val));
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_list();
    send_request(OP_READ, 5'd0, 32'd0);
    send_request(OP_DELETE, 5'd0, 32'd0);
    send_request(OP_INSERT, 5'd1, 32'hdead_beef);
    send_request(OP_SPARE, 5'd31, 32'hffff_ffff);
  endtask

  task automatic test_head_and_tail();
    send_request(OP_INSERT, 5'd0, VALUE_MAX);
    send_request(OP_INSERT, 5'd1, VALUE_MIN);
    send_request(OP_INSERT, 5'd0, 32'hffff_ffff);
    send_request(OP_INSERT, 5'd1, 32'd0);
    send_request(OP_READ, 5'd0, 32'd0);
    send_request(OP_SPARE, 5'd3, 32'd0);
  endtask

  task automatic test_full_list();
    int unsigned k;
    for (k = 0; k < 12; k++) begin
      send_request(OP_INSERT, (k % 2 == 0) ? 5'd0 : POS_W'(held_count), $urandom);
    end
    send_request(OP_INSERT, 5'd16, 32'h1234_5678);
    send_request(OP_INSERT, 5'd17, 32'h1234_5678);
    send_request(OP_READ, 5'd16, 32'd0);
    send_request(OP_DELETE, 5'd15, 32'd0);
    send_request(OP_DELETE, 5'd0, 32'd0);
    send_request(OP_READ, 5'd0, 32'd0);
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned       k;
    int unsigned       roll;
    bit                filling;
    logic [1:0]        op;
    logic [POS_W-1:0]  pos;
    logic [31:0]       val;
    filling = 1'b1;
    for (k = 0; k < n_items; k++) begin
      if (held_count == CAPACITY && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (held_count == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 4) op = OP_SPARE;
      else if (roll < 30) op = OP_READ;
      else if (roll < (filling ? 78 : 48)) op = OP_INSERT;
      else op = OP_DELETE;
      pos = pick_position(op);
      case ($urandom_range(0, 9))
        0: val = VALUE_MAX;
        1: val = VALUE_MIN;
        default: val = $urandom;
      endcase
      send_request(op, pos, val);
    end
  endtask

  task automatic test_pause_until_drained();
    test_random_traffic(20);
    wait_results_drained();
    test_random_traffic(20);
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d read_value %0d entry_count %0d",
               status_o, read_value_o, entry_count_o);
        fail_count++;
      end else begin
        due = pending_results.pop_front();
        if (status_o !== due.status) begin
          $error("status mismatch: expected %0d, actual %0d", due.status, status_o);
          fail_count++;
        end
        if (read_value_o !== due.read_value) begin
          $error("read_value mismatch: expected %0d, actual %0d",
                 $signed(due.read_value), read_value_o);
          fail_count++;
        end
        if (entry_count_o !== due.entry_count) begin
          $error("entry_count mismatch: expected %0d, actual %0d",
                 due.entry_count, entry_count_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    foreach (entry_model[i]) entry_model[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_list();
    test_head_and_tail();
    test_full_list();
    test_random_traffic(1000);
    test_pause_until_drained();
    idle_en = 1'b0;
    test_random_traffic(700);
    wait_results_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
